[hdl/mgss_pkg.sv]
// Package for the modular geometric series sum unit.
// Widths, reset modulus and sequencer state codes. No dependencies.
package mgss_pkg;
  localparam int DataWidth = 64;
  localparam int ModWidth  = DataWidth - 1;
  localparam int CntWidth  = $clog2(DataWidth);
  localparam logic [ModWidth-1:0] ModReset = ModWidth'(64'd1000000007);

  typedef logic [ModWidth-1:0] mod_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_RED   = 8'b0000_0010,
    ST_FIX   = 8'b0000_0100,
    ST_MSQ   = 8'b0000_1000,
    ST_MPP   = 8'b0001_0000,
    ST_ADD   = 8'b0010_0000,
    ST_MPR   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic start;
    mod_t a;
    mod_t b;
  } mul_req_t;
endpackage

[hdl/mgss_mulmod.sv]
// Bit-serial modular multiplier: one doubling and conditional add per cycle.
// Depends on mgss_pkg. Result valid with done, held until next start.
module mgss_mulmod
  import mgss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  input  mod_t     m,
  output logic     done,
  output mod_t     prod
);
  logic                busy_r, busy_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  mod_t                a_r, acc_r, acc_nxt;
  logic [DataWidth-1:0] b_r, b_nxt;
  logic                done_r, done_nxt;
  logic [ModWidth:0]   dbl, dsub, sum, ssub;
  mod_t                dred;

  always_comb begin
    dbl  = {acc_r, 1'b0};
    dsub = dbl - {1'b0, m};
    dred = dsub[ModWidth] ? acc_r << 1 : dsub[ModWidth-1:0];
    sum  = {1'b0, dred} + {1'b0, a_r};
    ssub = sum - {1'b0, m};
    acc_nxt  = acc_r;
    b_nxt    = b_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt  = '0;
      b_nxt    = {1'b0, req.b};
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r[DataWidth-1]) acc_nxt = ssub[ModWidth] ? sum[ModWidth-1:0] : ssub[ModWidth-1:0];
      else acc_nxt = dred;
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntWidth'(DataWidth-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    b_r   <= b_nxt;
    if (req.start) a_r <= req.a;
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

[hdl/mgss_reduce.sv]
// Restoring bit-serial reduction of a 64-bit magnitude modulo m.
// Depends on mgss_pkg. One quotient bit per cycle.
module mgss_reduce
  import mgss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DataWidth-1:0] mag,
  input  mod_t                 m,
  output logic                 done,
  output mod_t                 rem
);
  logic                 busy_r;
  logic                 done_r;
  logic [CntWidth-1:0]  cnt_r;
  logic [DataWidth-1:0] sh_r;
  mod_t                 rem_r;
  logic [ModWidth:0]    cat, dif;

  always_comb begin
    cat = {rem_r, sh_r[DataWidth-1]};
    dif = cat - {1'b0, m};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntWidth'(DataWidth-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      sh_r  <= mag;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= sh_r << 1;
      rem_r <= (cat >= {1'b0, m}) ? dif[ModWidth-1:0] : cat[ModWidth-1:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule

[hdl/modular_geometric_series_sum_unit.sv]
// Modular geometric series sum: (1 + r + ... + r^(n-1)) mod m; depends on mgss_pkg,
// mgss_mulmod, mgss_reduce. After accept the ratio is reduced modulo m, then count
// bits n[62:0] are taken from the top down. Per count bit: a setup state and two serial
// multiplies; a set bit adds an add state and one more multiply.
// Count <= 0 or modulus <= 1: out_valid in the cycle after accept. One item at a time,
// in_stall is high until the result is taken. Sync active-low reset; reset modulus 1000000007.
module modular_geometric_series_sum_unit
  import mgss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DataWidth-1:0]  in_ratio,
  input  logic [DataWidth-1:0]  in_term_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ModWidth-1:0]   out_series_sum,
  input  logic                  cfg_we,
  input  logic [ModWidth-1:0]   cfg_modulus
);
  state_t              st_r;
  mod_t                mod_r, m_r, r_r, s_r, p_r, res_r;
  logic [DataWidth-1:0] n_r;
  logic                neg_r;
  logic [CntWidth-1:0] bit_r;
  mul_req_t            mreq;
  logic                mdone, rdone, rstart, acc;
  mod_t                prod, rem, one, onep, add_sp;
  logic [ModWidth:0]   t1, t2;
  logic [DataWidth-1:0] mag;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign one      = (m_r == ModWidth'(1)) ? '0 : ModWidth'(1);
  assign t1       = {1'b0, one} + {1'b0, p_r};
  assign onep     = (t1 >= {1'b0, m_r}) ? ModWidth'(t1 - {1'b0, m_r}) : t1[ModWidth-1:0];
  assign t2       = {1'b0, s_r} + {1'b0, p_r};
  assign add_sp   = (t2 >= {1'b0, m_r}) ? ModWidth'(t2 - {1'b0, m_r}) : t2[ModWidth-1:0];
  assign mag      = in_ratio[DataWidth-1] ? (~in_ratio + 1'b1) : in_ratio;
  assign rstart   = acc;

  always_comb begin
    mreq = '{start: 1'b0, a: s_r, b: onep};
    if (st_r == ST_MSQ && mdone) mreq = '{start: 1'b1, a: p_r, b: p_r};
    else if (st_r == ST_FIX) mreq = '{start: 1'b1, a: s_r, b: onep};
    else if (st_r == ST_MPP && mdone && n_r[bit_r])
      mreq = '{start: 1'b0, a: p_r, b: r_r};
    else if (st_r == ST_ADD) mreq = '{start: 1'b1, a: p_r, b: r_r};
  end

  mgss_mulmod u_mul (.clk, .rst_n, .req(mreq), .m(m_r), .done(mdone), .prod);
  mgss_reduce u_red (.clk, .rst_n, .start(rstart), .mag, .m(mod_r == '0 ? ModWidth'(1) : mod_r),
                     .done(rdone), .rem);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      mod_r  <= ModReset;
    end else begin
      if (cfg_we) mod_r <= cfg_modulus;
      case (st_r)
        ST_IDLE: if (acc) begin
          st_r <= (in_term_count[DataWidth-1] || in_term_count == '0 || mod_r <= ModWidth'(1))
                  ? ST_DONE : ST_RED;
        end
        ST_RED: if (rdone) st_r <= ST_FIX;
        ST_FIX: st_r <= ST_MSQ;
        ST_MSQ: if (mdone) st_r <= ST_MPP;
        ST_MPP: if (mdone) begin
          if (n_r[bit_r]) st_r <= ST_ADD;
          else if (bit_r == '0) st_r <= ST_DONE;
          else st_r <= ST_FIX;
        end
        ST_ADD: st_r <= ST_MPR;
        ST_MPR: if (mdone) st_r <= (bit_r == '0) ? ST_DONE : ST_FIX;
        ST_DONE: if (!out_stall) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
    case (st_r)
      ST_IDLE: if (acc) begin
        m_r   <= (mod_r == '0) ? ModWidth'(1) : mod_r;
        n_r   <= in_term_count;
        neg_r <= in_ratio[DataWidth-1];
        res_r <= '0;
        s_r   <= '0;
        bit_r <= CntWidth'(DataWidth-2);
      end
      ST_RED: if (rdone) begin
        r_r <= (neg_r && rem != '0) ? m_r - rem : rem;
        p_r <= one;
      end
      ST_MSQ: if (mdone) s_r <= prod;
      ST_MPP: if (mdone) begin
        p_r <= prod;
        if (!n_r[bit_r]) begin
          if (bit_r == '0) res_r <= s_r;
          else bit_r <= bit_r - 1'b1;
        end
      end
      ST_ADD: s_r <= add_sp;
      ST_MPR: if (mdone) begin
        p_r <= prod;
        if (bit_r == '0) res_r <= s_r;
        else bit_r <= bit_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid      = (st_r == ST_DONE);
  assign out_series_sum = res_r;

  a_sum_lt_mod: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_series_sum < m_r || out_series_sum == '0))
    else $error("sum not reduced");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> in_stall) else $error("ready while busy");
  a_neg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_term_count[DataWidth-1]) |=> (out_valid && out_series_sum == '0))
    else $error("negative count not zero");
endmodule
